/* hw/rtl/assert_macros.svh */
// Assertion macros for the reminder alarm matcher.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/rem_pkg.sv */
// Types and constants for the reminder alarm matcher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rem_pkg;

   localparam logic [31:0] DAY_SECONDS = 32'd86400;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic KIND_CUSTOM = 1'b0;
   localparam logic KIND_REPEAT = 1'b1;

   localparam logic [2:0] EV_FIRST        = 3'd0;
   localparam logic [2:0] EV_FIRST_OFFSET = 3'd1;
   localparam logic [2:0] EV_WEEK         = 3'd2;
   localparam logic [2:0] EV_WEEK_OFFSET  = 3'd3;
   localparam logic [2:0] EV_MONTH        = 3'd4;
   localparam logic [2:0] EV_MONTH_OFFSET = 3'd5;
   localparam logic [2:0] EV_REPEAT       = 3'd6;
   localparam logic [2:0] EV_REPEAT_OFFSET = 3'd7;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  slot;
      logic        entry_valid;
      logic        entry_kind;
      logic [31:0] time_utc;
      logic [31:0] offset_time;
      logic [2:0]  weekday;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [6:0]  weekday_mask;
      logic [12:0] month_mask;
      logic [31:0] repeat_period;
   } req_type;

   typedef struct packed {
      logic [1:0] group_id;
      logic       item_id;
      logic [2:0] event_kind;
      logic       last;
   } rsp_type;

endpackage
`default_nettype wire

/* hw/rtl/rem_mod_serial.sv */
// Bit-serial remainder unit: one dividend bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module rem_mod_serial (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      remainder
);

   logic [31:0] quo_ff, quo_in;
   logic [31:0] div_ff, div_in;
   logic [31:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   assign trial = {rem_ff, quo_ff[31]};

   always_comb begin
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         div_in = divisor;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 32'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[31:0];
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

/* hw/rtl/reminder_alarm_matcher.sv */
// Reminder alarm matcher top level: entry table, scan sequencer, result strobe.
// Depends on rem_pkg, rem_mod_serial and assert_macros.svh.
// A write leaves busy low. A tick scans every entry: a valid entry passes through load,
// start, the serial remainder and 8 emit steps; an invalid one is skipped in the load step.
// At most one result per cycle as strobes; the receiver cannot stall. Sync reset invalidates all entries.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module reminder_alarm_matcher
   import rem_pkg::*;
#(
   parameter int GROUPS          = 4,
   parameter int ITEMS_PER_GROUP = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int ENTRY_COUNT = GROUPS * ITEMS_PER_GROUP;
   localparam int DEPTH = (ENTRY_COUNT < 8) ? ENTRY_COUNT : 8;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_FINAL = 3'd5;

   logic              valid_ff [DEPTH];
   logic              kind_mem [DEPTH];
   logic [31:0]       tgt_mem  [DEPTH];
   logic [31:0]       ofs_mem  [DEPTH];
   logic [2:0]        wday_mem [DEPTH];
   logic [4:0]        mday_mem [DEPTH];
   logic [6:0]        wmsk_mem [DEPTH];
   logic [12:0]       mmsk_mem [DEPTH];
   logic [31:0]       per_mem  [DEPTH];

   logic              kind_ff;
   logic [31:0]       tgt_ff, ofs_ff, per_ff;
   logic [2:0]        wday_ff;
   logic [4:0]        mday_ff;
   logic [6:0]        wmsk_ff;
   logic [12:0]       mmsk_ff;

   logic [31:0]       now_ff;
   logic [2:0]        cwday_ff;
   logic [4:0]        cmday_ff;
   logic [3:0]        cmon_ff;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W:0]    cnt_ff, cnt_in;
   logic [2:0]        ev_ff, ev_in;
   logic [7:0]        hits_ff, hits_in;
   logic              pend_ff, pend_in;
   rsp_type           pdat_ff, pdat_in;
   logic              rv_ff, rv_in;
   rsp_type           rd_ff, rd_in;

   logic              accept, do_write, mod_start;
   logic [IDX_W-1:0]  idx;
   logic [2:0]        scan_slot;
   logic [31:0]       op0, op1, op2, dist_t, dist_o;
   logic              done0, done1, done2;
   logic [31:0]       r0, r1, r2;
   logic              wk_ok, mo_ok, c_t, c_o;
   logic [7:0]        wk_shift;
   logic [15:0]       mo_shift;
   logic [7:0]        hit_vec;

   assign accept   = start && !busy;
   assign do_write = accept && (req_data.cmd == CMD_WRITE)
                     && ({29'd0, req_data.slot} < 32'(DEPTH));
   assign idx       = cnt_ff[IDX_W-1:0];
   assign scan_slot = 3'(cnt_ff);
   assign mod_start = (state_ff == S_START);

   always_ff @(posedge clock) begin
      if (do_write) begin
         kind_mem[req_data.slot[IDX_W-1:0]] <= req_data.entry_kind;
         tgt_mem[req_data.slot[IDX_W-1:0]]  <= req_data.time_utc;
         ofs_mem[req_data.slot[IDX_W-1:0]]  <= req_data.offset_time;
         wday_mem[req_data.slot[IDX_W-1:0]] <= req_data.weekday;
         mday_mem[req_data.slot[IDX_W-1:0]] <= req_data.day_of_month;
         wmsk_mem[req_data.slot[IDX_W-1:0]] <= req_data.weekday_mask;
         mmsk_mem[req_data.slot[IDX_W-1:0]] <= req_data.month_mask;
         per_mem[req_data.slot[IDX_W-1:0]]  <= req_data.repeat_period;
      end
      if (state_ff == S_LOAD) begin
         kind_ff <= kind_mem[idx];
         tgt_ff  <= tgt_mem[idx];
         ofs_ff  <= ofs_mem[idx];
         wday_ff <= wday_mem[idx];
         mday_ff <= mday_mem[idx];
         wmsk_ff <= wmsk_mem[idx];
         mmsk_ff <= mmsk_mem[idx];
         per_ff  <= per_mem[idx];
      end
      if (accept && (req_data.cmd == CMD_TICK)) begin
         now_ff   <= req_data.time_utc;
         cwday_ff <= req_data.weekday;
         cmday_ff <= req_data.day_of_month;
         cmon_ff  <= req_data.month;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (do_write && (req_data.slot[IDX_W-1:0] == IDX_W'(i))) begin
            valid_ff[i] <= req_data.entry_valid;
         end
      end
   end

   // operand steering: custom entries reduce mod a day, repeat entries reduce distance mod period
   assign dist_t = (now_ff > tgt_ff) ? now_ff - tgt_ff : tgt_ff - now_ff;
   assign dist_o = (now_ff > ofs_ff) ? now_ff - ofs_ff : ofs_ff - now_ff;
   assign op0 = (kind_ff == KIND_CUSTOM) ? now_ff : dist_t;
   assign op1 = (kind_ff == KIND_CUSTOM) ? tgt_ff : dist_o;
   assign op2 = ofs_ff;

   rem_mod_serial u_mod0 (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(op0),
      .divisor((kind_ff == KIND_CUSTOM) ? DAY_SECONDS : per_ff),
      .done(done0), .remainder(r0)
   );
   rem_mod_serial u_mod1 (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(op1),
      .divisor((kind_ff == KIND_CUSTOM) ? DAY_SECONDS : per_ff),
      .done(done1), .remainder(r1)
   );
   rem_mod_serial u_mod2 (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(op2),
      .divisor(DAY_SECONDS), .done(done2), .remainder(r2)
   );

   assign wk_shift = {1'b0, wmsk_ff} >> cwday_ff;
   assign mo_shift = {3'd0, mmsk_ff} >> cmon_ff;
   assign wk_ok = (wday_ff == cwday_ff) && wk_shift[0];
   assign mo_ok = (mday_ff == cmday_ff) && mo_shift[0];
   assign c_t   = (r0 == r1);
   assign c_o   = (r0 == r2);

   always_comb begin
      hit_vec = '0;
      hit_vec[EV_FIRST]        = (now_ff == tgt_ff);
      hit_vec[EV_FIRST_OFFSET] = (now_ff == ofs_ff);
      if (kind_ff == KIND_CUSTOM) begin
         hit_vec[EV_WEEK]         = wk_ok && c_t;
         hit_vec[EV_WEEK_OFFSET]  = wk_ok && c_o;
         hit_vec[EV_MONTH]        = mo_ok && c_t;
         hit_vec[EV_MONTH_OFFSET] = mo_ok && c_o;
      end else if (per_ff != 32'd0) begin
         hit_vec[EV_REPEAT]        = (r0 == 32'd0);
         hit_vec[EV_REPEAT_OFFSET] = (r1 == 32'd0);
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ev_in    = ev_ff;
      hits_in  = hits_ff;
      pend_in  = pend_ff;
      pdat_in  = pdat_ff;
      rv_in    = 1'b0;
      rd_in    = rd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_data.cmd == CMD_TICK)) begin
               state_in = S_LOAD;
               cnt_in   = '0;
               pend_in  = 1'b0;
            end
         end
         S_LOAD: begin
            if (cnt_ff == (IDX_W + 1)'(DEPTH)) begin
               state_in = S_FINAL;
            end else if (!valid_ff[idx]) begin
               cnt_in = cnt_ff + {{IDX_W{1'b0}}, 1'b1};
            end else begin
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (done0 && done1 && done2) begin
               hits_in  = hit_vec;
               ev_in    = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (hits_ff[ev_ff]) begin
               if (pend_ff) begin
                  rv_in = 1'b1;
                  rd_in = pdat_ff;
               end
               pend_in = 1'b1;
               pdat_in.group_id   = 2'(scan_slot / 3'(ITEMS_PER_GROUP));
               pdat_in.item_id    = 1'(scan_slot % 3'(ITEMS_PER_GROUP));
               pdat_in.event_kind = ev_ff;
               pdat_in.last       = 1'b0;
            end
            ev_in = ev_ff + 3'd1;
            if (ev_ff == EV_REPEAT_OFFSET) begin
               cnt_in   = cnt_ff + {{IDX_W{1'b0}}, 1'b1};
               state_in = S_LOAD;
            end
         end
         S_FINAL: begin
            if (pend_ff) begin
               rv_in      = 1'b1;
               rd_in      = pdat_ff;
               rd_in.last = 1'b1;
            end
            pend_in  = 1'b0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      ev_ff   <= ev_in;
      hits_ff <= hits_in;
      pdat_ff <= pdat_in;
      rd_ff   <= rd_in;
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

   `ASSERT_SAME(a_last_ends_scan, clock, reset, rsp_valid && rsp_data.last, !busy)
   `ASSERT_SAME(a_mid_in_scan, clock, reset, rsp_valid && !rsp_data.last, busy)
   `ASSERT_NEXT(a_write_no_busy, clock, reset, accept && (req_data.cmd == CMD_WRITE), !busy)

endmodule
`default_nettype wire
